[hdl/cave_pkg.sv]
// Package for the cave automaton row step: shared types and constants.
// Used by cave_row_gen and cave_automaton_row_step; depends on nothing.
package cave_pkg;

    // Fixed row width of the streaming ports.
    localparam int ROW_BITS = 64;

    // Configuration register widths.
    localparam int LIMIT_W = 4;
    localparam int WIDTH_W = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    // Neighbour count holds 0 to 8.
    localparam int NBR_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_DEATH_LIMIT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIRTH_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd2;

    // Rule settings handed to the row generator, width already clamped.
    typedef struct packed {
        logic [LIMIT_W-1:0] death_limit;
        logic [LIMIT_W-1:0] birth_limit;
        logic [WIDTH_W-1:0] eff_width;
    } gen_cfg_t;

    // One result request waiting in the output queue.
    typedef struct packed {
        logic                last;
        logic [ROW_BITS-1:0] cells;
    } out_entry_t;

endpackage

[hdl/cave_row_gen.sv]
// Next-generation logic for one row, all cells in parallel, from three rows.
// Depends on cave_pkg for the row width and the rule settings struct.
module cave_row_gen (
    input  cave_pkg::gen_cfg_t                cfg,
    input  logic [cave_pkg::ROW_BITS-1:0]     above,
    input  logic [cave_pkg::ROW_BITS-1:0]     mid,
    input  logic [cave_pkg::ROW_BITS-1:0]     below,
    output logic [cave_pkg::ROW_BITS-1:0]     next_cells
);

    localparam int RB = cave_pkg::ROW_BITS;

    logic [RB-1:0]                in_use;
    logic [RB+1:0]                ext_a;
    logic [RB+1:0]                ext_m;
    logic [RB+1:0]                ext_b;
    logic [cave_pkg::NBR_W-1:0]   nbr [RB];

    // Columns below the width are inside the grid.
    always_comb begin
        for (int c = 0; c < RB; c++) begin
            in_use[c] = (cave_pkg::WIDTH_W'(c) < cfg.eff_width);
        end
    end

    // Rows padded with live cells on both sides and beyond the width.
    always_comb begin
        ext_a[0]    = 1'b1;
        ext_m[0]    = 1'b1;
        ext_b[0]    = 1'b1;
        ext_a[RB+1] = 1'b1;
        ext_m[RB+1] = 1'b1;
        ext_b[RB+1] = 1'b1;
        for (int c = 0; c < RB; c++) begin
            ext_a[c+1] = in_use[c] ? above[c] : 1'b1;
            ext_m[c+1] = in_use[c] ? mid[c]   : 1'b1;
            ext_b[c+1] = in_use[c] ? below[c] : 1'b1;
        end
    end

    // Count eight neighbours and apply the survive and birth rules.
    always_comb begin
        for (int c = 0; c < RB; c++) begin
            nbr[c] = cave_pkg::NBR_W'(ext_a[c]) + cave_pkg::NBR_W'(ext_a[c+1])
                   + cave_pkg::NBR_W'(ext_a[c+2]) + cave_pkg::NBR_W'(ext_m[c])
                   + cave_pkg::NBR_W'(ext_m[c+2]) + cave_pkg::NBR_W'(ext_b[c])
                   + cave_pkg::NBR_W'(ext_b[c+1]) + cave_pkg::NBR_W'(ext_b[c+2]);
            if (ext_m[c+1]) begin
                next_cells[c] = in_use[c] && (nbr[c] >= cfg.death_limit);
            end else begin
                next_cells[c] = in_use[c] && (nbr[c] > cfg.birth_limit);
            end
        end
    end

endmodule

[hdl/cave_automaton_row_step.sv]
// Top level of the cave automaton row step: row buffers, config, output queue.
// Depends on cave_pkg and instantiates cave_row_gen twice.
//
// One generation of a cave-smoothing cellular automaton, streamed one row per
// request, top to bottom, with s_tlast on the last row. Cells outside the grid
// count as alive. Row r leaves when row r+1 is taken; the last row also emits
// itself, marked by m_tlast, and the block then starts a fresh grid. A row is
// taken every cycle while s_tready is high: all cells are computed in one pass
// from the two buffered rows and the incoming one, straight into a three-entry
// output queue whose head drives the master side. s_tready is high while the
// queue holds at most one result; a last row that closes a grid of two or more
// rows yields two results, so the following row waits until the master side
// has drained the queue to one result. Write configuration only while the
// block is idle.
module cave_automaton_row_step #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [cave_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cave_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input rows.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cave_pkg::ROW_BITS-1:0]       s_tdata,   // [63:0] row_cells
    input  logic                                s_tlast,   // final_row
    // Result rows.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cave_pkg::ROW_BITS-1:0]       m_tdata,   // [63:0] next_row_cells
    output logic                                m_tlast    // final_out
);

    localparam int RB    = cave_pkg::ROW_BITS;
    localparam int QD    = 3;
    localparam int QCW   = 2;
    localparam logic [cave_pkg::WIDTH_W-1:0] MAX_W = cave_pkg::WIDTH_W'(MAX_WIDTH);

    // Configuration registers.
    logic [cave_pkg::LIMIT_W-1:0] death_limit_reg;
    logic [cave_pkg::LIMIT_W-1:0] birth_limit_reg;
    logic [cave_pkg::WIDTH_W-1:0] grid_width_reg;

    // Row buffers.
    logic [RB-1:0] upper_reg,  upper_next;
    logic [RB-1:0] middle_reg, middle_next;
    logic          held_reg,   held_next;

    // Output queue, head at entry 0.
    cave_pkg::out_entry_t q_reg [QD];
    cave_pkg::out_entry_t q_next [QD];
    logic [QCW-1:0]       count_reg, count_next;

    cave_pkg::gen_cfg_t   gen_cfg;
    logic [cave_pkg::WIDTH_W-1:0] eff_width;
    logic [RB-1:0]        above_new;
    logic [RB-1:0]        res_mid;
    logic [RB-1:0]        res_last;
    cave_pkg::out_entry_t push_a;
    cave_pkg::out_entry_t push_b;
    logic [QCW-1:0]       push_n;
    logic [QCW-1:0]       base;
    logic                 accept;
    logic                 pop;

    // Clamp the width to one through MAX_WIDTH.
    always_comb begin
        if (grid_width_reg == '0) begin
            eff_width = cave_pkg::WIDTH_W'(1);
        end else if (grid_width_reg > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = grid_width_reg;
        end
        gen_cfg.death_limit = death_limit_reg;
        gen_cfg.birth_limit = birth_limit_reg;
        gen_cfg.eff_width   = eff_width;
    end

    // Handshakes.
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (count_reg <= QCW'(1));
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = q_reg[0].cells;
    assign m_tlast  = q_reg[0].last;

    // The row above the incoming one, seen from the last row's result.
    assign above_new = held_reg ? middle_reg : '1;

    // Result for the held middle row, with the incoming row below it.
    cave_row_gen u_gen_mid (
        .cfg        (gen_cfg),
        .above      (upper_reg),
        .mid        (middle_reg),
        .below      (s_tdata),
        .next_cells (res_mid)
    );

    // Result for the incoming row when it closes the grid.
    cave_row_gen u_gen_last (
        .cfg        (gen_cfg),
        .above      (above_new),
        .mid        (s_tdata),
        .below      ({RB{1'b1}}),
        .next_cells (res_last)
    );

    // Results of this request in stream order.
    always_comb begin
        push_b.cells = res_last;
        push_b.last  = 1'b1;
        if (held_reg) begin
            push_a.cells = res_mid;
            push_a.last  = 1'b0;
        end else begin
            push_a = push_b;
        end
        if (!accept) begin
            push_n = '0;
        end else begin
            push_n = QCW'(held_reg) + QCW'(s_tlast);
        end
    end

    // Queue update: shift out the head, then append new results.
    always_comb begin
        for (int i = 0; i < QD; i++) begin
            q_next[i] = q_reg[i];
        end
        base = count_reg;
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                q_next[i] = q_reg[i+1];
            end
            base = count_reg - QCW'(1);
        end
        for (int i = 0; i < QD; i++) begin
            if ((push_n != '0) && (QCW'(i) == base)) begin
                q_next[i] = push_a;
            end
            if ((push_n == QCW'(2)) && (QCW'(i) == base + QCW'(1))) begin
                q_next[i] = push_b;
            end
        end
        count_next = base + push_n;
    end

    // Row buffer update; the last row returns them to the empty grid.
    always_comb begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        held_next   = held_reg;
        if (accept) begin
            if (s_tlast) begin
                upper_next  = '1;
                middle_next = '0;
                held_next   = 1'b0;
            end else begin
                upper_next  = above_new;
                middle_next = s_tdata;
                held_next   = 1'b1;
            end
        end
    end

    // Control state, row buffers and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            upper_reg       <= '1;
            middle_reg      <= '0;
            held_reg        <= 1'b0;
            death_limit_reg <= cave_pkg::LIMIT_W'(4);
            birth_limit_reg <= cave_pkg::LIMIT_W'(4);
            grid_width_reg  <= cave_pkg::WIDTH_W'(64);
        end else begin
            count_reg  <= count_next;
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
            held_reg   <= held_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    cave_pkg::REG_DEATH_LIMIT: begin
                        death_limit_reg <= cfg_wdata[cave_pkg::LIMIT_W-1:0];
                    end
                    cave_pkg::REG_BIRTH_LIMIT: begin
                        birth_limit_reg <= cfg_wdata[cave_pkg::LIMIT_W-1:0];
                    end
                    cave_pkg::REG_GRID_WIDTH: begin
                        grid_width_reg <= cfg_wdata[cave_pkg::WIDTH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QD; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule
